>>> rtl/rc_pkg.sv
// ----------------------------------------------------------------------------
// Rational compare package
// Shared types and codes for the continued-fraction comparator.
// ----------------------------------------------------------------------------
package rc_pkg;

  localparam logic [1:0] ORDER_LESS    = 2'd0;
  localparam logic [1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [1:0] ORDER_GREATER = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_DIV_C,
    ST_DECIDE,
    ST_OUT
  } rc_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic div_start; // begin a division
    logic div_sel;   // 0: a/b, 1: c/d
    logic advance;   // swap to reciprocal of remainders
    logic finish;    // write result register
  } rc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic invalid;   // a denominator was zero at load
    logic decided;   // current round gives a verdict
  } rc_sts_t;

endpackage

>>> rtl/rc_ctrl.sv
// ----------------------------------------------------------------------------
// Rational compare controller
// Sequences load, two divisions per round, decision and output hand-off.
// ----------------------------------------------------------------------------
module rc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rc_pkg::rc_cmd_t cmd_o,
  input  rc_pkg::rc_sts_t sts_i
);
  import rc_pkg::*;

  rc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        if (sts_i.invalid) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV_C;
        end
      end
      ST_DIV_C: begin
        if (sts_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          state_d         = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) begin
          if (sts_i.decided) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_OUT;
          end else begin
            cmd_o.advance   = 1'b1;
            state_d         = ST_DIV_A;
          end
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/rc_datapath.sv
// ----------------------------------------------------------------------------
// Rational compare datapath
// Fraction registers, one shared radix-2 divider and the verdict logic.
// ----------------------------------------------------------------------------
module rc_datapath #(
  parameter int VALUE_WIDTH = 63
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] fn_i,
  input  logic [VALUE_WIDTH-1:0] fd_i,
  input  logic [VALUE_WIDTH-1:0] sn_i,
  input  logic [VALUE_WIDTH-1:0] sd_i,
  input  rc_pkg::rc_cmd_t        cmd_i,
  output rc_pkg::rc_sts_t        sts_o,
  output logic [1:0]             order_o,
  output logic                   invalid_o
);
  import rc_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] a_q, b_q, c_q, d_q;
  logic         flip_q, inv_q;
  // divider
  logic [W-1:0] dq_q, dr_q, ddiv_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  // stored quotient/remainder of a/b
  logic [W-1:0] qa_q, ra_q;
  logic [1:0]   order_q;
  logic         oinv_q;

  logic [W:0]   trial;
  logic [W-1:0] shifted_r;
  logic         fin;

  assign trial     = {dr_q, dq_q[W-1]} - {1'b0, ddiv_q};
  assign fin       = busy_q && (cnt_q == CW'(1));

  // verdict on completion of c/d (next values)
  logic [W-1:0] qc, rc;
  logic         lt, dec;
  logic [1:0]   ord;
  always_comb begin
    qc  = {dq_q[W-2:0], ~trial[W]};
    rc  = trial[W] ? {dr_q[W-2:0], dq_q[W-1]} : trial[W-1:0];
    dec = 1'b1;
    ord = ORDER_EQUAL;
    if (qa_q != qc) begin
      lt  = (qa_q < qc) ^ flip_q;
      ord = lt ? ORDER_LESS : ORDER_GREATER;
    end else if (ra_q == '0 || rc == '0) begin
      lt  = (ra_q == '0) ^ flip_q;
      if (ra_q == '0 && rc == '0) ord = ORDER_EQUAL;
      else                        ord = lt ? ORDER_LESS : ORDER_GREATER;
    end else begin
      lt  = 1'b0;
      dec = 1'b0;
    end
  end
  assign shifted_r = '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= fn_i;
      b_q    <= fd_i;
      c_q    <= sn_i;
      d_q    <= sd_i;
      flip_q <= 1'b0;
      inv_q  <= (fd_i == '0) || (sd_i == '0);
    end
    if (cmd_i.div_start) begin
      dq_q   <= cmd_i.div_sel ? c_q : a_q;
      ddiv_q <= cmd_i.div_sel ? d_q : b_q;
      dr_q   <= shifted_r;
    end else if (busy_q) begin
      dq_q <= {dq_q[W-2:0], ~trial[W]};
      dr_q <= trial[W] ? {dr_q[W-2:0], dq_q[W-1]} : trial[W-1:0];
    end
    // a/b result is captured as c/d division is launched
    if (cmd_i.div_start && cmd_i.div_sel) begin
      qa_q <= {dq_q[W-2:0], ~trial[W]};
      ra_q <= trial[W] ? {dr_q[W-2:0], dq_q[W-1]} : trial[W-1:0];
    end
    if (cmd_i.advance) begin
      a_q    <= b_q;
      b_q    <= ra_q;
      c_q    <= d_q;
      d_q    <= rc;
      flip_q <= ~flip_q;
    end
    if (cmd_i.finish) begin
      order_q <= inv_q ? ORDER_EQUAL : ord;
      oinv_q  <= inv_q;
    end
  end

  assign sts_o.div_done = fin;
  assign sts_o.invalid  = inv_q;
  assign sts_o.decided  = dec;
  assign order_o        = order_q;
  assign invalid_o      = oinv_q;

endmodule

>>> rtl/rational_compare_top.sv
// ----------------------------------------------------------------------------
// Rational compare top level
// Exact three-way ordering of two nonnegative fractions.
// ----------------------------------------------------------------------------
// One transaction at a time. Each continued-fraction round runs two
// VALUE_WIDTH-step divisions on one shared restoring divider; rounds repeat
// until the quotients or remainders decide the order, up to roughly 90 rounds
// at 63 bits. A zero denominator skips the divisions (invalid set, order
// equal). The result is held on the master side until taken; the next item is
// accepted after that.
// ----------------------------------------------------------------------------
module rational_compare_top #(
  parameter int VALUE_WIDTH = 63
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [62:0] first_numerator, [125:63] first_denominator,
  // [188:126] second_numerator, [251:189] second_denominator, [255:252] zero
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] order, [2] invalid, [7:3] zero
  output logic [7:0]   m_axis_tdata
);
  import rc_pkg::*;

  rc_cmd_t cmd;
  rc_sts_t sts;
  logic [1:0] order;
  logic       invalid;

  rc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // only the low VALUE_WIDTH bits of each field take part
  rc_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .fn_i     (s_axis_tdata[VALUE_WIDTH-1:0]),
    .fd_i     (s_axis_tdata[63 +: VALUE_WIDTH]),
    .sn_i     (s_axis_tdata[126 +: VALUE_WIDTH]),
    .sd_i     (s_axis_tdata[189 +: VALUE_WIDTH]),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .order_o  (order),
    .invalid_o(invalid)
  );

  assign m_axis_tdata = {5'b0, invalid, order};

endmodule

>>> rtl/rc_checker.sv
// ----------------------------------------------------------------------------
// Rational compare checker
// Port-level checks on the stream handshakes and result encoding.
// ----------------------------------------------------------------------------
module rc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  import rc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while result pending");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("illegal order code");

  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == ORDER_EQUAL)
    else $error("invalid result not equal");

  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while busy");

endmodule

bind rational_compare_top rc_checker u_rc_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational compare testbench
// Drives fraction pairs into the comparator over the stream bus, predicts the
// ordering by lock-step continued-fraction expansion and checks each result.
// ----------------------------------------------------------------------------
module tb_top;
  import rc_pkg::*;

  localparam int VW = 63;
  localparam int N_RANDOM = 100;

  typedef logic [VW-1:0] val_t;

  typedef struct packed {
    val_t fn;
    val_t fd;
    val_t sn;
    val_t sd;
  } frac_pair_t;

  typedef struct packed {
    logic [1:0] order;
    logic       invalid;
  } verdict_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;

  rational_compare_top #(.VALUE_WIDTH(VW)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock: 4 ns period
  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  frac_pair_t pending_pairs[$];
  verdict_t   expected_verdicts[$];
  int         fail_count = 0;
  int         send_idle_pct = 9;
  int         recv_idle_pct = 59;
  bit         hold_off_go = 1'b0;   // raised once by the stimulus
  bit         hold_off_used = 1'b0;
  int         hold_off_cycles = 0;  // long receiver hold-off, counted down

  // ordering of fn/fd against sn/sd by lock-step continued fractions
  function automatic verdict_t order_fractions(frac_pair_t p);
    verdict_t v;
    val_t a, b, c, d, qa, qc, ra, rc, t;
    bit flip, lt;
    v.invalid = 1'b0;
    v.order = ORDER_EQUAL;
    if (p.fd == '0 || p.sd == '0) begin
      v.invalid = 1'b1;
      return v;
    end
    a = p.fn; b = p.fd; c = p.sn; d = p.sd; flip = 1'b0;
    forever begin
      qa = a / b;
      qc = c / d;
      if (qa != qc) begin
        lt = (qa < qc) ^ flip;
        v.order = lt ? ORDER_LESS : ORDER_GREATER;
        return v;
      end
      ra = a % b;
      rc = c % d;
      if (ra == '0 || rc == '0) begin
        if (ra == '0 && rc == '0) return v;
        lt = (ra == '0) ^ flip;
        v.order = lt ? ORDER_LESS : ORDER_GREATER;
        return v;
      end
      t = b; b = ra; a = t;
      t = d; d = rc; c = t;
      flip = ~flip;
    end
  endfunction

  function automatic val_t rand_val();
    val_t v;
    int width;
    v = val_t'({$urandom, $urandom});
    // mostly modest magnitudes, sometimes full width
    width = ($urandom_range(0, 3) == 0) ? VW : $urandom_range(1, 24);
    if (width < VW) v = v & ((val_t'(1) << width) - val_t'(1));
    return v;
  endfunction

  task automatic push_pair(val_t fn, val_t fd, val_t sn, val_t sd);
    frac_pair_t p;
    p.fn = fn; p.fd = fd; p.sn = sn; p.sd = sd;
    pending_pairs = {pending_pairs, p};
  endtask

  task automatic push_random_pair();
    val_t fn, fd, k;
    fn = rand_val();
    fd = rand_val();
    if (fd == '0 && $urandom_range(0, 7) != 0) fd = val_t'(1);
    case ($urandom_range(0, 3))
      0: begin
        // scaled copy: equal values, deep expansions
        k = val_t'($urandom_range(1, 5));
        fn = fn & 63'h0fff_ffff; fd = (fd & 63'h0fff_ffff) | val_t'(1);
        push_pair(fn, fd, fn * k, fd * k);
      end
      1: push_pair(fn, fd, fn + val_t'($urandom_range(0, 1)), fd); // near neighbours
      default: push_pair(fn, fd, rand_val(), rand_val() | val_t'($urandom_range(0, 1)));
    endcase
  endtask

  // registered view of the input handshake from the last rising edge
  logic s_axis_tready_q;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s_axis_tready_q <= 1'b0;
    else         s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
  end

  // driver: inputs change on the falling edge
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready_q) begin
      // previous transaction taken (or none offered)
      if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        frac_pair_t p;
        p = pending_pairs.pop_front();
        s_axis_tdata  <= {4'b0, p.sd, p.sn, p.fd, p.fn};
        s_axis_tvalid <= 1'b1;
        expected_verdicts = {expected_verdicts, order_fractions(p)};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off_go && !hold_off_used) begin
      hold_off_used   <= 1'b1;
      hold_off_cycles <= 3000;
      m_axis_tready   <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready   <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: results sampled on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        verdict_t exp_v;
        exp_v = expected_verdicts.pop_front();
        if (m_axis_tdata[1:0] !== exp_v.order) begin
          $error("order: expected %0d, actual %0d", exp_v.order, m_axis_tdata[1:0]);
          fail_count++;
        end
        if (m_axis_tdata[2] !== exp_v.invalid) begin
          $error("invalid: expected %0d, actual %0d", exp_v.invalid, m_axis_tdata[2]);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || s_axis_tvalid || expected_verdicts.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    val_t max_v;
    max_v = '1;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero denominators, zero numerators, extremes, equal values
    push_pair(63'd5, 63'd0, 63'd3, 63'd7);
    push_pair(63'd5, 63'd7, 63'd3, 63'd0);
    push_pair(63'd0, 63'd0, 63'd0, 63'd0);
    push_pair(63'd0, 63'd1, 63'd0, 63'd9);
    push_pair(63'd0, 63'd3, 63'd1, 63'd3);
    push_pair(63'd2, 63'd4, 63'd1, 63'd2);
    push_pair(max_v, 63'd1, max_v, 63'd1);
    push_pair(max_v, max_v, 63'd1, 63'd1);
    push_pair(max_v, max_v - 63'd1, max_v - 63'd1, max_v - 63'd2);
    push_pair(63'd1, max_v, 63'd0, max_v);
    push_pair(max_v, 63'd1, 63'd1, max_v);
    push_pair(63'd3, 63'd2, 63'd4, 63'd3);
    push_pair(63'd4, 63'd3, 63'd3, 63'd2);
    push_pair(63'd13, 63'd8, 63'd21, 63'd13); // Fibonacci neighbours: long expansions
    push_pair(63'd7540113804746346429, 63'd4660046610375530309,
              63'd4660046610375530309, 63'd2880067194370816120);
    push_pair(63'd7, 63'd3, 63'd14, 63'd6);
    push_pair(63'd5, 63'd2, 63'd3, 63'd1);
    push_pair(max_v, 63'h2aaa_aaaa_aaaa_aaaa, max_v, 63'h5555_5555_5555_5555);

    // phase 1: sender 9 %, receiver 59 %; long hold-off to fill the block
    for (int i = 0; i < N_RANDOM / 3; i++) push_random_pair();
    hold_off_go = 1'b1;
    wait_drained();
    send_idle_pct = 59; recv_idle_pct = 9;
    for (int i = 0; i < N_RANDOM / 3; i++) push_random_pair();
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < N_RANDOM / 3; i++) push_random_pair();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog: worst-case item time with stalls, several times over
  initial begin
    #(120 * 40000 * 4);
    $display("tb: failure");
    $finish;
  end

endmodule
